// ===== sv/m3i_pkg.sv =====
// shared constants for the 3x3 matrix inverse unit
`default_nettype none
package m3i_pkg;

  typedef logic [3:0] elem_idx_t;

  // cofactor k = m[CF_A]*m[CF_B] - m[CF_C]*m[CF_D], elements in row-major order
  localparam elem_idx_t CF_A [9] = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd2, 4'd3, 4'd1, 4'd0};
  localparam elem_idx_t CF_B [9] = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd3, 4'd7, 4'd6, 4'd4};
  localparam elem_idx_t CF_C [9] = '{4'd5, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd4, 4'd0, 4'd1};
  localparam elem_idx_t CF_D [9] = '{4'd7, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd7, 4'd3};

  // integer bits of the input format
  localparam int unsigned IN_INT_BITS = 4;

  // pipeline depth ahead of the dividers
  localparam int unsigned FRONT_STAGES = 4;

endpackage
`default_nettype wire

// ===== sv/m3i_front.sv =====
// cofactor and determinant stages
`default_nettype none
module m3i_front import m3i_pkg::*; #(
  parameter int unsigned IW = 16
) (
  input  wire logic                         clk,
  input  wire logic [FRONT_STAGES-1:0]      en,
  input  wire logic [9*IW-1:0]              in_data,
  output logic      [9*2*IW-1:0]            cof_data,
  output logic      [3*IW:0]                det,
  output logic                              degen
);
  localparam int unsigned CW = 2 * IW;
  localparam int unsigned DW = 3 * IW + 1;
  localparam int unsigned TW = 3 * IW;

  logic signed [IW-1:0] a [9];
  logic signed [CW-1:0] pa [9];
  logic signed [CW-1:0] pb [9];
  logic signed [IW-1:0] r1_a [3];
  logic                 r1_eq;
  logic signed [CW-1:0] cof2 [9];
  logic signed [IW-1:0] r2_a [3];
  logic                 r2_eq;
  logic signed [CW-1:0] cof3 [9];
  logic signed [TW-1:0] t3 [3];
  logic                 r3_eq;
  logic signed [CW-1:0] cof4 [9];
  logic signed [DW-1:0] det_sum;
  logic                 all_eq;

  always_comb begin
    all_eq = 1'b1;
    for (int i = 0; i < 9; i++) begin
      a[i] = in_data[i*IW +: IW];
      if (a[i] != a[0]) all_eq = 1'b0;
    end
  end

  // products
  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < 9; i++) begin
        pa[i] <= CW'(a[CF_A[i]] * a[CF_B[i]]);
        pb[i] <= CW'(a[CF_C[i]] * a[CF_D[i]]);
      end
      for (int i = 0; i < 3; i++) r1_a[i] <= a[i];
      r1_eq <= all_eq;
    end
  end

  // cofactors
  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int i = 0; i < 9; i++) cof2[i] <= pa[i] - pb[i];
      for (int i = 0; i < 3; i++) r2_a[i] <= r1_a[i];
      r2_eq <= r1_eq;
    end
  end

  // first-row expansion terms
  always_ff @(posedge clk) begin
    if (en[2]) begin
      t3[0] <= TW'(r2_a[0] * cof2[0]);
      t3[1] <= TW'(r2_a[1] * cof2[3]);
      t3[2] <= TW'(r2_a[2] * cof2[6]);
      for (int i = 0; i < 9; i++) cof3[i] <= cof2[i];
      r3_eq <= r2_eq;
    end
  end

  assign det_sum = DW'(t3[0]) + DW'(t3[1]) + DW'(t3[2]);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      det   <= det_sum;
      degen <= r3_eq || (det_sum == '0);
      for (int i = 0; i < 9; i++) cof4[i] <= cof3[i];
    end
  end

  always_comb begin
    for (int i = 0; i < 9; i++) cof_data[i*CW +: CW] = cof4[i];
  end

endmodule
`default_nettype wire

// ===== sv/m3i_div_lane.sv =====
// pipelined restoring divider for one inverse element, rounded and saturated
`default_nettype none
module m3i_div_lane #(
  parameter int unsigned CW = 32,
  parameter int unsigned DW = 49,
  parameter int unsigned SH = 28,
  parameter int unsigned OW = 32
) (
  input  wire logic          clk,
  input  wire logic [OW+1:0] en,
  input  wire logic [CW-1:0] cof,
  input  wire logic [DW-1:0] det,
  input  wire logic          zero,
  output logic      [OW-1:0] quot
);
  localparam int unsigned NW = CW + SH;
  localparam int unsigned XW = ((NW > DW + OW) ? NW : DW + OW) + 1;

  logic [XW-1:0] rem  [OW+1];
  logic [OW-1:0] q    [OW+1];
  logic [DW-1:0] dm   [OW+1];
  logic          neg  [OW+1];
  logic          ovf  [OW+1];
  logic          zr   [OW+1];

  logic [CW-1:0] cmag;
  logic [DW-1:0] dmag;
  logic [XW-1:0] num;

  assign cmag = cof[CW-1] ? (~cof + 1'b1) : cof;
  assign dmag = det[DW-1] ? (~det + 1'b1) : det;
  assign num  = XW'(cmag) << SH;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      rem[0] <= num;
      q[0]   <= '0;
      dm[0]  <= dmag;
      neg[0] <= cof[CW-1] ^ det[DW-1];
      ovf[0] <= num >= (XW'(dmag) << OW);
      zr[0]  <= zero;
    end
  end

  // one quotient bit per stage, msb first
  for (genvar i = 1; i <= OW; i++) begin : g_bit
    logic [XW-1:0] trial;
    logic          ge;
    assign trial = XW'(dm[i-1]) << (OW - i);
    assign ge    = rem[i-1] >= trial;
    always_ff @(posedge clk) begin
      if (en[i]) begin
        rem[i] <= ge ? rem[i-1] - trial : rem[i-1];
        q[i]   <= q[i-1] | (OW'(ge) << (OW - i));
        dm[i]  <= dm[i-1];
        neg[i] <= neg[i-1];
        ovf[i] <= ovf[i-1];
        zr[i]  <= zr[i-1];
      end
    end
  end

  localparam logic [OW:0] LIM_NEG = (OW+1)'(1) << (OW - 1);
  localparam logic [OW:0] LIM_POS = LIM_NEG - 1'b1;

  logic          rnd;
  logic [OW:0]   qr;
  logic [OW-1:0] res;

  assign rnd = (rem[OW] << 1) >= XW'(dm[OW]);
  assign qr  = {1'b0, q[OW]} + (OW+1)'(rnd);

  always_comb begin
    if (zr[OW]) begin
      res = '0;
    end else if (neg[OW]) begin
      if (ovf[OW] || qr > LIM_NEG) res = LIM_NEG[OW-1:0];
      else res = ~qr[OW-1:0] + 1'b1;
    end else begin
      if (ovf[OW] || qr > LIM_POS) res = LIM_POS[OW-1:0];
      else res = qr[OW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[OW+1]) quot <= res;
  end

endmodule
`default_nettype wire

// ===== sv/matrix3x3_inverse_unit.sv =====
// top level of the 3x3 matrix inverse unit
// Takes one 3x3 matrix of signed Q4.12 elements per beat and returns its
// determinant (Q13.36, exact) and its inverse in Q16.16, rounded to nearest
// with ties away from zero and saturated. A singular or all-equal matrix
// clears the invertible flag in tuser and gives an all-zero inverse. The
// unit is fully pipelined: a new matrix may enter every cycle unless every
// stage is full and m_tready is low. The pipe has OUT_WIDTH + 6 register
// stages (four stages of multiply and cofactor work, then a restoring divider
// per element that settles one quotient bit per stage, plus a setup and a
// rounding stage), and the first stage loads at the edge that takes the matrix.
// Every stage holds its beat while the stage after it is full and stalled,
// so empty stages keep filling while a result waits on the output.
`default_nettype none
module matrix3x3_inverse_unit import m3i_pkg::*; #(
  parameter int unsigned IN_WIDTH  = 16,
  parameter int unsigned OUT_WIDTH = 32
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  s_tvalid,
  output logic       s_tready,
  // m00 m01 m02 m10 m11 m12 m20 m21 m22, IN_WIDTH each, from bit 0 up
  input  wire logic [((9*IN_WIDTH+7)/8)*8-1:0] s_tdata,
  output logic       m_tvalid,
  input  wire logic  m_tready,
  // inv00 .. inv22 (OUT_WIDTH each), det_value (3*IN_WIDTH+1), from bit 0 up
  output logic [((9*OUT_WIDTH+3*IN_WIDTH+1+7)/8)*8-1:0] m_tdata,
  // invertible
  output logic       m_tuser
);
  localparam int unsigned CW  = 2 * IN_WIDTH;
  localparam int unsigned DW  = 3 * IN_WIDTH + 1;
  localparam int unsigned SH  = (IN_WIDTH - IN_INT_BITS) + OUT_WIDTH / 2;
  localparam int unsigned NS  = FRONT_STAGES + OUT_WIDTH + 2;

  logic [NS-1:0] v;
  logic [NS-1:0] en;

  // a stage takes a new beat when it is empty or its contents move on
  always_comb begin
    en[NS-1] = !v[NS-1] || m_tready;
    for (int k = NS - 2; k >= 0; k--) en[k] = !v[k] || en[k+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= s_tvalid;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  assign s_tready = en[0];
  assign m_tvalid = v[NS-1];

  logic [9*CW-1:0] cof_data;
  logic [DW-1:0]   det;
  logic            degen;

  m3i_front #(.IW(IN_WIDTH)) u_front (
    .clk      (clk),
    .en       (en[FRONT_STAGES-1:0]),
    .in_data  (s_tdata[9*IN_WIDTH-1:0]),
    .cof_data (cof_data),
    .det      (det),
    .degen    (degen)
  );

  logic [OUT_WIDTH-1:0] inv [9];

  // adjugate is the transposed cofactor matrix, so lane i reads its own cofactor
  for (genvar i = 0; i < 9; i++) begin : g_lane
    m3i_div_lane #(.CW(CW), .DW(DW), .SH(SH), .OW(OUT_WIDTH)) u_lane (
      .clk  (clk),
      .en   (en[NS-1:FRONT_STAGES]),
      .cof  (cof_data[i*CW +: CW]),
      .det  (det),
      .zero (degen),
      .quot (inv[i])
    );
  end

  // determinant and flag ride alongside the divider stages
  logic [DW-1:0] det_d [OUT_WIDTH+2];
  logic          dg_d  [OUT_WIDTH+2];

  always_ff @(posedge clk) begin
    for (int j = 0; j < OUT_WIDTH + 2; j++) begin
      if (en[FRONT_STAGES+j]) begin
        det_d[j] <= (j == 0) ? det : det_d[(j == 0) ? 0 : j - 1];
        dg_d[j]  <= (j == 0) ? degen : dg_d[(j == 0) ? 0 : j - 1];
      end
    end
  end

  always_comb begin
    m_tdata = '0;
    for (int i = 0; i < 9; i++) m_tdata[i*OUT_WIDTH +: OUT_WIDTH] = inv[i];
    m_tdata[9*OUT_WIDTH +: DW] = det_d[OUT_WIDTH+1];
  end

  assign m_tuser = !dg_d[OUT_WIDTH+1];

  // singular result carries an all-zero inverse
  a_zero_inv: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata[9*OUT_WIDTH-1:0] == '0))
    else $error("singular result with nonzero inverse");

  // an invertible result carries a nonzero determinant
  a_det_nz: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata[9*OUT_WIDTH +: DW] != '0))
    else $error("invertible result with zero determinant");

  // pipeline is empty and ready right after reset
  a_rst_ready: assert property (@(posedge clk) rst |=> (s_tready && !m_tvalid))
    else $error("pipeline not empty after reset");

endmodule
`default_nettype wire
